// File: src/sac_pkg.sv
// Package with shared types and constants of the set-associative LRU cache model.
`default_nettype none
package sac_pkg;

	// Widths of the configuration registers, the command field and the counters.
	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int SET_BITS_W = 3;
	localparam int OFFSET_BITS_W = 6;
	localparam int WAYS_W = 3;
	localparam int CMD_W = 2;
	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

	// Offset bits are kept in the range 1 to 32.
	localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_MAX = 6'd32;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS = 2'd0,
		CFG_OFFSET_BITS = 2'd1,
		CFG_WAYS = 2'd2
	} cfg_idx_t;

	// Access kinds.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_STORE = 2'd1,
		CMD_MODIFY = 2'd2
	} cmd_t;

	// Current configuration, already held in range.
	typedef struct packed {
		logic [SET_BITS_W-1:0] set_bits;
		logic [OFFSET_BITS_W-1:0] offset_bits;
		logic [WAYS_W-1:0] ways;
	} cfg_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EXEC
	} bk_state_t;

endpackage
`default_nettype wire

// File: src/sac_if.sv
// Request and response channel interfaces of the cache model.
`default_nettype none
interface sac_req_if #(
	parameter int ADDR_WIDTH = 64
);
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [ADDR_WIDTH-1:0] address;

	modport source (output valid, command, address, input ready);
	modport sink (input valid, command, address, output ready);
endinterface

interface sac_rsp_if;
	logic valid;
	logic ready;
	logic was_hit;
	logic did_evict;
	logic last_of_item;
	logic [31:0] hits_total;
	logic [31:0] misses_total;
	logic [31:0] evictions_total;

	modport source (output valid, was_hit, did_evict, last_of_item, hits_total,
		misses_total, evictions_total, input ready);
	modport sink (input valid, was_hit, did_evict, last_of_item, hits_total,
		misses_total, evictions_total, output ready);
endinterface
`default_nettype wire

// File: src/sac_queue.sv
// Two-entry queue of decoded accesses between the front and the back end.
`default_nettype none
module sac_queue #(
	parameter int W = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire logic [W-1:0] push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end
endmodule
`default_nettype wire

// File: src/sac_front.sv
// Front end: accepts requests, splits the address and expands a modify into two accesses.
`default_nettype none
module sac_front #(
	parameter int MAX_SET_BITS = 5,
	parameter int ADDR_WIDTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sac_pkg::cfg_t cfg,
	sac_req_if.sink req,
	output logic push_valid,
	input wire logic push_ready,
	output logic [MAX_SET_BITS+ADDR_WIDTH-2:0] push_data
);
	import sac_pkg::*;

	localparam int TAG_W = ADDR_WIDTH - 2;
	localparam int ENT_W = MAX_SET_BITS + TAG_W + 1;

	logic pend_q;
	logic [ENT_W-1:0] held_q;
	logic fire;
	logic [ADDR_WIDTH-1:0] off_shift;
	logic [ADDR_WIDTH-1:0] tag_shift;
	logic [MAX_SET_BITS-1:0] set_mask;
	logic [MAX_SET_BITS-1:0] set_idx;
	logic [TAG_W-1:0] tag;
	logic is_modify;

	// Address split by the configured field widths.
	always_comb begin
		off_shift = req.address >> cfg.offset_bits;
		tag_shift = req.address >> ({1'b0, cfg.offset_bits} + 7'(cfg.set_bits));
		set_mask = ~({MAX_SET_BITS{1'b1}} << cfg.set_bits);
		set_idx = off_shift[MAX_SET_BITS-1:0] & set_mask;
		tag = tag_shift[TAG_W-1:0];
		is_modify = (req.command == CMD_MODIFY);
	end

	assign req.ready = !pend_q && push_ready;
	assign fire = req.valid && req.ready;
	assign push_valid = pend_q || (req.valid && !pend_q);
	assign push_data = pend_q ? held_q : {set_idx, tag, !is_modify};

	// The second access of a modify goes out in a following cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (fire && is_modify) begin
			pend_q <= 1'b1;
		end else if (pend_q && push_ready) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) held_q <= {set_idx, tag, 1'b1};
	end
endmodule
`default_nettype wire

// File: src/sac_back.sv
// Back end: reads a set, looks up tags, updates LRU ranks and counters, drives responses.
`default_nettype none
module sac_back #(
	parameter int MAX_SET_BITS = 5,
	parameter int MAX_WAYS = 4,
	parameter int ADDR_WIDTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sac_pkg::cfg_t cfg,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire logic [MAX_SET_BITS+ADDR_WIDTH-2:0] pop_data,
	sac_rsp_if.source rsp
);
	import sac_pkg::*;

	localparam int TAG_W = ADDR_WIDTH - 2;
	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	// Tag and rank rows; valid bits live in flip-flops.
	logic [TAG_W-1:0] tag_mem [SETS][MAX_WAYS];
	logic [RANK_W-1:0] rank_mem [SETS][MAX_WAYS];
	logic [MAX_WAYS-1:0] valid_q [SETS];

	bk_state_t state_q, state_d;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic last_q;
	logic [TAG_W-1:0] tag_rd_q [MAX_WAYS];
	logic [RANK_W-1:0] rank_rd_q [MAX_WAYS];

	logic out_valid_q, hit_o_q, evict_o_q, last_o_q;
	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;

	logic take, exec;
	logic [MAX_WAYS-1:0] in_use, match, row_valid;
	logic hit, found_inv, evict;
	logic [WAY_W-1:0] hit_way, inv_way, lru_way, tgt_way;
	logic [RANK_W-1:0] best;
	int old_rank;
	logic [RANK_W-1:0] new_rank [MAX_WAYS];

	// Sequencer: take an access, read its set, then update it.
	always_comb begin
		state_d = state_q;
		take = 1'b0;
		exec = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					take = 1'b1;
					state_d = BK_READ;
				end
			end
			BK_READ: state_d = BK_EXEC;
			BK_EXEC: begin
				if (!out_valid_q || rsp.ready) begin
					exec = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end
	assign pop_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// Latch the access and read its row.
	always_ff @(posedge clk) begin
		if (take) begin
			set_q <= pop_data[TAG_W+1 +: MAX_SET_BITS];
			tag_q <= pop_data[1 +: TAG_W];
			last_q <= pop_data[0];
			for (int w = 0; w < MAX_WAYS; w++) begin
				tag_rd_q[w] <= tag_mem[pop_data[TAG_W+1 +: MAX_SET_BITS]][w];
				rank_rd_q[w] <= rank_mem[pop_data[TAG_W+1 +: MAX_SET_BITS]][w];
			end
		end
	end

	// Lookup, victim choice and rank update.
	always_comb begin
		row_valid = valid_q[set_q];
		hit = 1'b0;
		found_inv = 1'b0;
		hit_way = '0;
		inv_way = '0;
		lru_way = '0;
		best = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = (w < int'(cfg.ways));
			match[w] = in_use[w] && row_valid[w] && (tag_rd_q[w] == tag_q);
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (in_use[w] && !row_valid[w]) begin
				found_inv = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (in_use[w] && (w == 0 || rank_rd_q[w] > best)) begin
				best = rank_rd_q[w];
				lru_way = WAY_W'(w);
			end
		end
		evict = !hit && !found_inv;
		tgt_way = hit ? hit_way : (found_inv ? inv_way : lru_way);
		old_rank = hit ? int'(rank_rd_q[hit_way])
			: (found_inv ? int'(cfg.ways) : int'(rank_rd_q[lru_way]));
		for (int x = 0; x < MAX_WAYS; x++) begin
			if (x == int'(tgt_way)) begin
				new_rank[x] = '0;
			end else if (in_use[x] && row_valid[x] && int'(rank_rd_q[x]) < old_rank
				&& int'(rank_rd_q[x]) < MAX_WAYS - 1) begin
				new_rank[x] = rank_rd_q[x] + RANK_W'(1);
			end else begin
				new_rank[x] = rank_rd_q[x];
			end
		end
	end

	// Row write back.
	always_ff @(posedge clk) begin
		if (exec) begin
			for (int w = 0; w < MAX_WAYS; w++) rank_mem[set_q][w] <= new_rank[w];
			if (!hit) tag_mem[set_q][tgt_way] <= tag_q;
		end
	end

	// Valid bits, counters and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) valid_q[s] <= '0;
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) out_valid_q <= 1'b0;
			if (exec) begin
				out_valid_q <= 1'b1;
				valid_q[set_q][tgt_way] <= 1'b1;
				if (hit) begin
					if (hit_cnt_q != CNT_MAX) hit_cnt_q <= hit_cnt_q + 1'b1;
				end else if (miss_cnt_q != CNT_MAX) begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
				if (evict && evict_cnt_q != CNT_MAX) evict_cnt_q <= evict_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			hit_o_q <= hit;
			evict_o_q <= evict;
			last_o_q <= last_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.was_hit = hit_o_q;
	assign rsp.did_evict = evict_o_q;
	assign rsp.last_of_item = last_o_q;
	assign rsp.hits_total = hit_cnt_q;
	assign rsp.misses_total = miss_cnt_q;
	assign rsp.evictions_total = evict_cnt_q;

	// An eviction only happens on a miss.
	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		exec && evict |-> !hit) else $error("eviction on a hit");

	// Evictions never outnumber misses.
	a_evict_le_miss: assert property (@(posedge clk) disable iff (!arst_n)
		evict_cnt_q <= miss_cnt_q) else $error("eviction count above miss count");

	// Counters never go down; this checks the miss counter.
	a_miss_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> miss_cnt_q >= $past(miss_cnt_q)) else $error("miss count decreased");

	// A response is only produced from the update state.
	a_exec_state: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> state_q == BK_EXEC) else $error("update outside its state");
endmodule
`default_nettype wire

// File: src/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache model: configuration and the two halves.
//
// Each request is one load, store or modify; a modify yields two responses, the second
// always a hit. In the back end each cache access passes the idle state, which takes it
// from the queue and reads the set's tag and rank row from memory, then the read state,
// then the update state, which compares, picks the LRU victim and writes the row back
// once the earlier response, if any, is accepted; only then is the next access taken. A
// two-entry queue separates address decode from the lookup, and a response register lets
// the next access be taken and read while a response waits. Valid bits and counters clear
// at reset with no clearing pass. Configuration values are clamped into range and must
// only be written while no request is in flight.
`default_nettype none
module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = 5,
	parameter int MAX_WAYS = 4,
	parameter int ADDR_WIDTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_en,
	input wire logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
	sac_req_if.sink request,
	sac_rsp_if.source response
);
	import sac_pkg::*;

	localparam int ENT_W = MAX_SET_BITS + ADDR_WIDTH - 1;
	localparam logic [SET_BITS_W-1:0] SET_HI =
		SET_BITS_W'((MAX_SET_BITS > 7) ? 7 : MAX_SET_BITS);
	localparam logic [WAYS_W-1:0] WAYS_HI = WAYS_W'((MAX_WAYS > 7) ? 7 : MAX_WAYS);

	cfg_t cfg_q;
	logic [SET_BITS_W-1:0] wr_set;
	logic [OFFSET_BITS_W-1:0] wr_off;
	logic [WAYS_W-1:0] wr_ways;
	logic push_valid, push_ready, pop_valid, pop_ready;
	logic [ENT_W-1:0] push_data, pop_data;

	// Clamp written values into range.
	always_comb begin
		wr_set = cfg_data[SET_BITS_W-1:0];
		if (wr_set == '0) wr_set = SET_BITS_W'(1);
		else if (wr_set > SET_HI) wr_set = SET_HI;
		wr_off = cfg_data;
		if (wr_off == '0) wr_off = OFFSET_BITS_W'(1);
		else if (wr_off > OFFSET_BITS_MAX) wr_off = OFFSET_BITS_MAX;
		wr_ways = cfg_data[WAYS_W-1:0];
		if (wr_ways == '0) wr_ways = WAYS_W'(1);
		else if (wr_ways > WAYS_HI) wr_ways = WAYS_HI;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits <= SET_BITS_W'(1);
			cfg_q.offset_bits <= OFFSET_BITS_W'(1);
			cfg_q.ways <= WAYS_W'(1);
		end else if (cfg_en) begin
			case (cfg_index)
				CFG_SET_BITS: cfg_q.set_bits <= wr_set;
				CFG_OFFSET_BITS: cfg_q.offset_bits <= wr_off;
				CFG_WAYS: cfg_q.ways <= wr_ways;
				default: ;
			endcase
		end
	end

	sac_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .req(request),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	sac_queue #(.W(ENT_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
	);

	sac_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
		.ADDR_WIDTH(ADDR_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
		.rsp(response)
	);
endmodule
`default_nettype wire
